>>> hw/rtl/wmwc_pkg.sv
// Shared constants, command types and state types of the water mask window counter.
`timescale 1ns / 1ps

package wmwc_pkg;

    localparam int COL_W            = 7;
    localparam int ROW_W            = 7;
    localparam int SHORE_W          = 4;
    localparam int TEXEL_W          = 8;
    localparam int COORD_W          = 11;
    localparam int SPAN_W           = 5;
    localparam int WEIGHT_W         = 4;
    localparam int COUNT_W          = 9;
    localparam int PROD_W           = COUNT_W + WEIGHT_W;
    localparam int SHORE_RESET      = 4;
    localparam int SHORE_MAX        = 8;
    localparam int REACH_EXTRA      = 3;
    localparam int REACH_MAX        = SHORE_MAX + REACH_EXTRA;
    localparam int WEIGHT_BASE      = 8;
    localparam int WEIGHT_FRAC_BITS = 2;
    localparam int TEXEL_MAX        = 255;
    localparam int LINE_LEN         = 2 * REACH_MAX + 2;
    localparam int LINE_IDX_W       = $clog2(LINE_LEN);

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_QUERY,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic                 wet;
        logic [COORD_W-1:0]   col_first;
        logic [COORD_W-1:0]   col_last;
        logic [COORD_W-1:0]   row_first;
        logic [COORD_W-1:0]   row_last;
        logic [SPAN_W-1:0]    span;
        logic [WEIGHT_W-1:0]  weight;
    } cmd_t;

    typedef struct packed {
        logic empty;
        cmd_t head;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_FIN
    } back_state_t;

endpackage

>>> hw/rtl/wmwc_if.sv
// Valid/ready channel interfaces for input words and result words.
`timescale 1ns / 1ps

interface wmwc_in_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [wmwc_pkg::COL_W-1:0] col;
    logic [wmwc_pkg::ROW_W-1:0] row;
    logic                      is_water;

    modport source (output valid, output mode, output col, output row, output is_water,
                    input ready);
    modport sink (input valid, input mode, input col, input row, input is_water,
                  output ready);
endinterface

interface wmwc_out_if;
    logic                        valid;
    logic                        ready;
    logic [wmwc_pkg::TEXEL_W-1:0] texel;
    logic                        saturated;
    logic                        out_of_range;

    modport source (output valid, output texel, output saturated, output out_of_range,
                    input ready);
    modport sink (input valid, input texel, input saturated, input out_of_range,
                  output ready);
endinterface

>>> hw/rtl/water_mask_window_count.sv
// Top level of the water mask window counter: front end, command queue and back end.
`timescale 1ns / 1ps

// Channel   Direction  Words
// in_ch     sink       mode, col, row, is_water
// out_ch    source     texel, saturated, out_of_range
// cfg       write      shore_size (cfg_we, cfg_wdata)
//
// A map write is stored by the back end as it leaves the queue; a write outside the map is dropped at the front.
// A query scans (cols + 1) * (rows + 1) map cells, one read per cycle on the single
// memory read port.
// A query outside the computable range scans nothing and returns a flagged word.
// The map is not cleared by reset; reset clears the control state and sets shore_size to four.
// A two-entry queue lets the input accept words while the back end scans or the output stalls.

module water_mask_window_count #(
    parameter int MAP_WIDTH  = 128,
    parameter int MAP_HEIGHT = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    wmwc_in_if.sink                       in_ch,
    wmwc_out_if.source                    out_ch,
    input  logic                          cfg_we,
    input  logic [wmwc_pkg::SHORE_W-1:0]  cfg_wdata
);

    logic                     push;
    logic                     full;
    logic                     pop;
    wmwc_pkg::cmd_t           push_cmd;
    wmwc_pkg::queue_status_t  q_status;

    wmwc_front #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    wmwc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .status   (q_status)
    );

    wmwc_back #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q      (q_status),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

>>> hw/rtl/wmwc_front.sv
// Front end: shore register, input word classification and window bounds.
`timescale 1ns / 1ps

module wmwc_front #(
    parameter int MAP_WIDTH  = 128,
    parameter int MAP_HEIGHT = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    wmwc_in_if.sink                       in_ch,
    input  logic                          cfg_we,
    input  logic [wmwc_pkg::SHORE_W-1:0]  cfg_wdata,
    input  logic                          q_full,
    output logic                          push,
    output wmwc_pkg::cmd_t                push_cmd
);

    localparam int CW = wmwc_pkg::COORD_W;
    localparam logic [CW-1:0] W_LIM = CW'(MAP_WIDTH);
    localparam logic [CW-1:0] H_LIM = CW'(MAP_HEIGHT);
    localparam logic [CW-1:0] ONE   = CW'(1);

    logic [wmwc_pkg::SHORE_W-1:0]  shore_reg;
    logic [wmwc_pkg::SHORE_W-1:0]  shore_eff;
    logic [wmwc_pkg::SHORE_W-1:0]  reach;
    logic [CW-1:0]                 x;
    logic [CW-1:0]                 y;
    logic [CW-1:0]                 rch;
    logic [CW-1:0]                 col_first;
    logic [CW-1:0]                 col_last;
    logic                          in_map;
    logic                          query_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shore_reg <= wmwc_pkg::SHORE_W'(wmwc_pkg::SHORE_RESET);
        end
        else if (cfg_we)
        begin
            shore_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        shore_eff = (shore_reg > wmwc_pkg::SHORE_W'(wmwc_pkg::SHORE_MAX))
                  ? wmwc_pkg::SHORE_W'(wmwc_pkg::SHORE_MAX) : shore_reg;
        reach     = shore_eff + wmwc_pkg::SHORE_W'(wmwc_pkg::REACH_EXTRA);
        x         = CW'(in_ch.col);
        y         = CW'(in_ch.row);
        rch       = CW'(reach);
        in_map    = (x < W_LIM) && (y < H_LIM);
        query_ok  = (x < W_LIM - ONE) && (y != '0) && (y < H_LIM);
        col_first = (x >= rch) ? x - rch : '0;
        col_last  = (x + rch > W_LIM - ONE) ? W_LIM - ONE : x + rch;

        push_cmd           = '0;
        push_cmd.wet       = in_ch.is_water;
        push_cmd.weight    = wmwc_pkg::WEIGHT_W'(wmwc_pkg::WEIGHT_BASE) - shore_eff;
        if (!in_ch.mode)
        begin
            push_cmd.kind      = wmwc_pkg::CMD_WRITE;
            push_cmd.col_first = x;
            push_cmd.row_first = y;
        end
        else
        begin
            push_cmd.kind      = query_ok ? wmwc_pkg::CMD_QUERY : wmwc_pkg::CMD_REJECT;
            push_cmd.col_first = col_first;
            push_cmd.col_last  = col_last;
            push_cmd.row_first = (y > rch) ? y - rch - ONE : '0;
            push_cmd.row_last  = (y + rch > H_LIM) ? H_LIM - ONE : y + rch - ONE;
            push_cmd.span      = wmwc_pkg::SPAN_W'(col_last - col_first + ONE);
        end
    end

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full && (in_ch.mode || in_map);

endmodule

>>> hw/rtl/wmwc_queue.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module wmwc_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  wmwc_pkg::cmd_t           push_cmd,
    output logic                     full,
    input  logic                     pop,
    output wmwc_pkg::queue_status_t  status
);

    wmwc_pkg::cmd_t  slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      fill_reg;
    logic [1:0]      fill_next;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full         = fill_reg == 2'd2;
    assign status.empty = fill_reg == 2'd0;
    assign status.head  = slot_reg[rd_ptr_reg];

endmodule

>>> hw/rtl/wmwc_back.sv
// Back end: water map memory, window scan with a line buffer, weighting and result register.
`timescale 1ns / 1ps

module wmwc_back #(
    parameter int MAP_WIDTH  = 128,
    parameter int MAP_HEIGHT = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wmwc_pkg::queue_status_t  q,
    output logic                     pop,
    wmwc_out_if.source               out_ch
);

    localparam int XW    = $clog2(MAP_WIDTH);
    localparam int YW    = $clog2(MAP_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = wmwc_pkg::COORD_W;
    localparam int LL    = wmwc_pkg::LINE_LEN;
    localparam int LIW   = wmwc_pkg::LINE_IDX_W;
    localparam int SCW   = wmwc_pkg::PROD_W - wmwc_pkg::WEIGHT_FRAC_BITS;

    logic                          mem [DEPTH];
    logic                          rbit_reg;

    wmwc_pkg::back_state_t         state_reg;
    wmwc_pkg::back_state_t         state_next;
    wmwc_pkg::cmd_t                cmd_reg;
    logic [CW-1:0]                 cx_reg;
    logic [CW-1:0]                 cy_reg;
    logic                          rd_valid_reg;
    logic                          rd_en_reg;
    logic [LL-1:0]                 line_reg;
    logic [wmwc_pkg::COUNT_W-1:0]  count_reg;
    logic                          out_valid_reg;
    logic [wmwc_pkg::TEXEL_W-1:0]  texel_reg;
    logic                          sat_reg;
    logic                          oor_reg;

    logic                          slot_free;
    logic                          scan_end;
    logic                          mem_we;
    logic                          rd_issue;
    logic                          start;
    logic                          load_out;
    logic                          load_oor;
    logic                          hit;
    logic [LIW-1:0]                tap_a;
    logic [LIW-1:0]                tap_b;
    logic [wmwc_pkg::PROD_W-1:0]   prod;
    logic [SCW-1:0]                scaled;
    logic                          sat;
    logic [AW-1:0]                 waddr;
    logic [AW-1:0]                 raddr;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign scan_end  = (cx_reg == cmd_reg.col_last) && (cy_reg == cmd_reg.row_last);
    assign waddr     = {q.head.row_first[YW-1:0], q.head.col_first[XW-1:0]};
    assign raddr     = {cy_reg[YW-1:0], cx_reg[XW-1:0]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wmwc_pkg::BK_IDLE:
            begin
                if (!q.empty && q.head.kind == wmwc_pkg::CMD_QUERY)
                begin
                    state_next = wmwc_pkg::BK_SCAN;
                end
            end
            wmwc_pkg::BK_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = wmwc_pkg::BK_DRAIN;
                end
            end
            wmwc_pkg::BK_DRAIN:
            begin
                state_next = wmwc_pkg::BK_FIN;
            end
            wmwc_pkg::BK_FIN:
            begin
                if (slot_free)
                begin
                    state_next = wmwc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = wmwc_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        mem_we   = 1'b0;
        rd_issue = 1'b0;
        start    = 1'b0;
        load_out = 1'b0;
        load_oor = 1'b0;
        unique case (state_reg)
            wmwc_pkg::BK_IDLE:
            begin
                if (!q.empty)
                begin
                    unique case (q.head.kind)
                        wmwc_pkg::CMD_WRITE:
                        begin
                            pop    = 1'b1;
                            mem_we = 1'b1;
                        end
                        wmwc_pkg::CMD_QUERY:
                        begin
                            pop   = 1'b1;
                            start = 1'b1;
                        end
                        wmwc_pkg::CMD_REJECT:
                        begin
                            pop      = slot_free;
                            load_out = slot_free;
                            load_oor = 1'b1;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            wmwc_pkg::BK_SCAN:
            begin
                rd_issue = 1'b1;
            end
            wmwc_pkg::BK_DRAIN:
            begin
            end
            wmwc_pkg::BK_FIN:
            begin
                load_out = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= q.head.wet;
        end
    end

    always_ff @(posedge clk)
    begin
        rbit_reg <= mem[raddr];
    end

    assign tap_a = LIW'(cmd_reg.span - wmwc_pkg::SPAN_W'(1));
    assign tap_b = LIW'(cmd_reg.span);
    assign hit   = rd_valid_reg && rd_en_reg && rbit_reg && line_reg[0]
                && line_reg[tap_a] && line_reg[tap_b];
    assign prod   = wmwc_pkg::PROD_W'(count_reg) * wmwc_pkg::PROD_W'(cmd_reg.weight);
    assign scaled = prod[wmwc_pkg::PROD_W-1:wmwc_pkg::WEIGHT_FRAC_BITS];
    assign sat    = scaled > SCW'(wmwc_pkg::TEXEL_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wmwc_pkg::BK_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_issue;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg   <= q.head;
            cx_reg    <= q.head.col_first;
            cy_reg    <= q.head.row_first;
            count_reg <= '0;
        end
        else
        begin
            if (rd_issue)
            begin
                if (cx_reg == cmd_reg.col_last)
                begin
                    cx_reg <= cmd_reg.col_first;
                    cy_reg <= cy_reg + CW'(1);
                end
                else
                begin
                    cx_reg <= cx_reg + CW'(1);
                end
            end
            if (hit)
            begin
                count_reg <= count_reg + wmwc_pkg::COUNT_W'(1);
            end
        end
        rd_en_reg <= (cx_reg != cmd_reg.col_first) && (cy_reg != cmd_reg.row_first);
        if (rd_valid_reg)
        begin
            line_reg <= {line_reg[LL-2:0], rbit_reg};
        end
        if (load_out)
        begin
            if (load_oor)
            begin
                texel_reg <= '0;
                sat_reg   <= 1'b0;
                oor_reg   <= 1'b1;
            end
            else
            begin
                texel_reg <= sat ? wmwc_pkg::TEXEL_W'(wmwc_pkg::TEXEL_MAX)
                                 : wmwc_pkg::TEXEL_W'(scaled);
                sat_reg   <= sat;
                oor_reg   <= 1'b0;
            end
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.texel        = texel_reg;
    assign out_ch.saturated    = sat_reg;
    assign out_ch.out_of_range = oor_reg;

endmodule

>>> hw/rtl/wmwc_checker.sv
// Port-level assertions for the water mask window counter and their bind.
`timescale 1ns / 1ps

module wmwc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [wmwc_pkg::TEXEL_W-1:0]  texel,
    input  logic                          saturated,
    input  logic                          out_of_range
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(texel) && $stable(saturated)
                                    && $stable(out_of_range))
        else $error("result word changed while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> texel == '0 && !saturated)
        else $error("out of range word carries a count");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> texel == wmwc_pkg::TEXEL_W'(wmwc_pkg::TEXEL_MAX))
        else $error("saturated word is not clipped to the maximum");

endmodule

bind water_mask_window_count wmwc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .texel        (out_ch.texel),
    .saturated    (out_ch.saturated),
    .out_of_range (out_ch.out_of_range)
);
